FILE: sv/scsi_ips_pkg.sv
package scsi_ips_pkg;

	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_DATA_OUT = 3'd1;
	localparam logic [2:0] PH_DATA_IN  = 3'd2;
	localparam logic [2:0] PH_COMMAND  = 3'd3;
	localparam logic [2:0] PH_STATUS   = 3'd4;
	localparam logic [2:0] PH_MSG_OUT  = 3'd5;
	localparam logic [2:0] PH_MSG_IN   = 3'd6;

	// bus phase lines as reported in the chip status register
	localparam logic [2:0] BP_DATA_OUT = 3'd0;
	localparam logic [2:0] BP_DATA_IN  = 3'd1;
	localparam logic [2:0] BP_COMMAND  = 3'd2;
	localparam logic [2:0] BP_STATUS   = 3'd3;
	localparam logic [2:0] BP_MSG_OUT  = 3'd6;
	localparam logic [2:0] BP_MSG_IN   = 3'd7;

	localparam logic [7:0] CMD_NONE       = 8'h00;
	localparam logic [7:0] CMD_FLUSH      = 8'h01;
	localparam logic [7:0] CMD_SELECT     = 8'h41;
	localparam logic [7:0] CMD_XFER       = 8'h10;
	localparam logic [7:0] CMD_DMA        = 8'h80;
	localparam logic [7:0] CMD_XFER_DMA   = CMD_XFER | CMD_DMA;
	localparam logic [7:0] CMD_COMPLETE   = 8'h11;
	localparam logic [7:0] CMD_MSG_ACCEPT = 8'h12;
	localparam logic [7:0] CMD_SET_ATN    = 8'h1a;

	localparam logic [7:0] MSG_SAVE_PTR   = 8'h02;
	localparam logic [7:0] MSG_DISCONNECT = 8'h04;

	localparam logic [2:0] CC_OK         = 3'd0;
	localparam logic [2:0] CC_NO_CONNECT = 3'd1;
	localparam logic [2:0] CC_RESET      = 3'd2;
	localparam logic [2:0] CC_ERROR      = 3'd3;
	localparam logic [2:0] CC_PARITY     = 3'd4;

	localparam logic REQ_START = 1'b0;

	typedef struct packed {
		logic        req_type;
		logic [2:0]  target_id;
		logic [23:0] transfer_length;
		logic [7:0]  chip_status;
		logic [7:0]  interrupt_flags;
		logic [7:0]  pio_reg;
		logic [7:0]  fifo_first_byte;
		logic [7:0]  fifo_second_byte;
	} req_t;

	typedef struct packed {
		logic        command_valid;
		logic [7:0]  chip_command;
		logic [2:0]  select_target;
		logic [23:0] transfer_count;
		logic        done_res;
		logic [2:0]  completion_code;
		logic [7:0]  completed_status;
		logic [7:0]  completed_message;
		logic [2:0]  phase_now;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [2:0] bus_phase;
		logic [7:0] saved_status;
		logic [7:0] saved_message;
	} seq_state_t;

	function automatic res_t cmd_res(logic [7:0] code, logic [2:0] tgt, logic [23:0] cnt);
		res_t r;
		r = '0;
		r.command_valid = 1'b1;
		r.chip_command = code;
		r.select_target = tgt;
		r.transfer_count = cnt;
		return r;
	endfunction

	function automatic res_t done_res(logic [2:0] code, logic [7:0] st, logic [7:0] msg);
		res_t r;
		r = '0;
		r.done_res = 1'b1;
		r.completion_code = code;
		r.completed_status = st;
		r.completed_message = msg;
		return r;
	endfunction

endpackage

FILE: sv/scsi_ips_req_if.sv
interface scsi_ips_req_if;
	logic valid;
	logic ready;
	scsi_ips_pkg::req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/scsi_ips_res_if.sv
interface scsi_ips_res_if;
	logic valid;
	logic ready;
	scsi_ips_pkg::res_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/scsi_ips_decode.sv
module scsi_ips_decode (
	input  scsi_ips_pkg::req_t       item,
	input  scsi_ips_pkg::seq_state_t st,
	output scsi_ips_pkg::seq_state_t st_next,
	output scsi_ips_pkg::res_t       res0,
	output scsi_ips_pkg::res_t       res1,
	output logic                     two
);
	import scsi_ips_pkg::*;

	seq_state_t nxt;
	res_t r0;
	res_t r1;
	logic two_c;

	always_comb begin
		nxt = st;
		r0 = '0;
		r1 = '0;
		two_c = 1'b0;
		if (item.req_type == REQ_START) begin
			nxt.bus_phase = PH_COMMAND;
			nxt.saved_status = '0;
			nxt.saved_message = '0;
			r0 = cmd_res(CMD_FLUSH, item.target_id, '0);
			r1 = cmd_res(CMD_SELECT, item.target_id, '0);
			two_c = 1'b1;
		end else if (item.interrupt_flags[7]) begin
			nxt.bus_phase = PH_IDLE;
			r0 = done_res(CC_RESET, '0, '0);
		end else if (item.pio_reg[7]) begin
			nxt.bus_phase = PH_IDLE;
			r0 = done_res(CC_ERROR, '0, '0);
		end else if (item.chip_status[5]) begin
			nxt.bus_phase = PH_IDLE;
			r0 = done_res(CC_PARITY, '0, '0);
		end else if (item.chip_status[6]) begin
			nxt.bus_phase = PH_IDLE;
			r0 = done_res(CC_ERROR, '0, '0);
		end else if (item.interrupt_flags[5]) begin
			nxt.bus_phase = PH_IDLE;
			if (st.bus_phase == PH_MSG_IN) begin
				r0 = done_res(CC_OK, st.saved_status, st.saved_message);
			end else begin
				r0 = done_res(CC_NO_CONNECT, '0, '0);
			end
		end else begin
			case (item.chip_status[2:0]) inside
				BP_DATA_OUT, BP_DATA_IN: begin
					if (item.interrupt_flags[4]) begin
						nxt.bus_phase = item.chip_status[0] ? PH_DATA_IN : PH_DATA_OUT;
						r0 = cmd_res(CMD_FLUSH, '0, '0);
						r1 = cmd_res(CMD_XFER_DMA, '0, item.transfer_length);
						two_c = 1'b1;
					end
				end
				BP_COMMAND: begin
					nxt.bus_phase = PH_COMMAND;
				end
				BP_STATUS: begin
					nxt.bus_phase = PH_STATUS;
					r0 = cmd_res(CMD_FLUSH, '0, '0);
					r1 = cmd_res(CMD_COMPLETE, '0, '0);
					two_c = 1'b1;
				end
				BP_MSG_OUT: begin
					nxt.bus_phase = PH_MSG_OUT;
					r0 = cmd_res(CMD_SET_ATN, '0, '0);
					r1 = cmd_res(CMD_MSG_ACCEPT, '0, '0);
					two_c = 1'b1;
				end
				BP_MSG_IN: begin
					nxt.bus_phase = PH_MSG_IN;
					nxt.saved_status = item.fifo_first_byte;
					nxt.saved_message = item.fifo_second_byte;
					if (item.fifo_second_byte == MSG_SAVE_PTR ||
					    item.fifo_second_byte == MSG_DISCONNECT) begin
						r0 = cmd_res(CMD_SET_ATN, '0, '0);
						r1 = cmd_res(CMD_MSG_ACCEPT, '0, '0);
						two_c = 1'b1;
					end else begin
						r0 = cmd_res(CMD_MSG_ACCEPT, '0, '0);
					end
				end
				default: begin
				end
			endcase
		end
		r0.phase_now = nxt.bus_phase;
		r1.phase_now = nxt.bus_phase;
		r0.last = !two_c;
		r1.last = 1'b1;
	end

	assign st_next = nxt;
	assign res0 = r0;
	assign res1 = r1;
	assign two = two_c;

endmodule

FILE: sv/scsi_initiator_phase_sequencer.sv
// SCSI initiator bus phase sequencer. Each request transaction is a start (select a target)
// or a chip interrupt event; it gives one or two result transactions, the final one marked
// by last. A request is taken into an input register, decoded against the held bus phase and
// saved status and message bytes, and its first result is loaded into the result register
// once that register can take it. Results leave at one per cycle while the receiver is ready,
// through that single result register; a second result waits in a holding register behind
// the first. While a result waits to be taken, one further request is still accepted into
// the input register; after that the input stalls until no second result is held and the
// result register is free.
module scsi_initiator_phase_sequencer (
	input logic           clk,
	input logic           arst_n,
	scsi_ips_req_if.sink  req,
	scsi_ips_res_if.source res
);
	import scsi_ips_pkg::*;

	logic       valid_s1;
	req_t       item_s1;
	seq_state_t state_q;
	seq_state_t state_next;
	res_t       res0;
	res_t       res1;
	logic       two;
	logic       commit;
	logic       out_valid_q;
	res_t       out_q;
	logic       pend_valid_q;
	res_t       pend_q;

	scsi_ips_decode u_decode (
		.item    (item_s1),
		.st      (state_q),
		.st_next (state_next),
		.res0    (res0),
		.res1    (res1),
		.two     (two)
	);

	assign commit = valid_s1 && !pend_valid_q && (!out_valid_q || res.ready);
	assign req.ready = !valid_s1 || commit;
	assign res.valid = out_valid_q;
	assign res.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q <= '0;
			out_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (commit) begin
				state_q <= state_next;
				out_valid_q <= 1'b1;
				pend_valid_q <= two;
			end else if (pend_valid_q && res.ready) begin
				pend_valid_q <= 1'b0;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.payload;
		end
		if (commit) begin
			out_q <= res0;
			pend_q <= res1;
		end else if (pend_valid_q && res.ready) begin
			out_q <= pend_q;
		end
	end

`ifndef SYNTH
	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("held second result without a first");

	a_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> !out_q.last)
		else $error("first of two results marked last");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.done_res) |-> (out_q.last && !out_q.command_valid))
		else $error("completion not a lone result");

	a_pend_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_valid_q && res.ready) |=> (out_valid_q && out_q.last && !pend_valid_q))
		else $error("second result not moved forward");
`endif

endmodule

FILE: dv/tb_scsi_initiator_phase_sequencer.sv
`timescale 1ns / 1ps

module tb_scsi_initiator_phase_sequencer;
	import scsi_ips_pkg::*;

	localparam int unsigned ITEM_TARGET  = 1750;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned HOLD_AT      = 300;
	localparam int unsigned HOLD_CYCLES  = 400;

	localparam logic REQ_EVENT = ~REQ_START;

	// reserved bus phase codes
	localparam logic [2:0] BP_RESERVED_A = 3'd4;
	localparam logic [2:0] BP_RESERVED_B = 3'd5;

	localparam int INT_BUS_RESET  = 7;
	localparam int INT_DISCONNECT = 5;
	localparam int INT_SERVICE    = 4;
	localparam int ST_PARITY      = 5;
	localparam int ST_GROSS       = 6;
	localparam int PIO_ERROR      = 7;

	typedef enum int {
		FAULT_BUS_RESET,
		FAULT_PIO,
		FAULT_PARITY,
		FAULT_GROSS,
		FAULT_DISCONNECT
	} fault_e;

	class phase_sequence_checker;
		logic [2:0] bus_phase;
		logic [7:0] saved_status;
		logic [7:0] saved_message;
		res_t expected_results[$];
		int unsigned mismatches;

		function new();
			bus_phase = PH_IDLE;
			saved_status = '0;
			saved_message = '0;
			mismatches = 0;
		endfunction

		function res_t issue(logic [7:0] code, logic [2:0] tgt, logic [23:0] cnt);
			res_t r;
			r = '0;
			r.command_valid = 1'b1;
			r.chip_command = code;
			r.select_target = tgt;
			r.transfer_count = cnt;
			return r;
		endfunction

		function res_t conclude(logic [2:0] code, logic [7:0] st, logic [7:0] msg);
			res_t r;
			r = '0;
			r.done_res = 1'b1;
			r.completion_code = code;
			r.completed_status = st;
			r.completed_message = msg;
			return r;
		endfunction

		function void note_request(req_t rq);
			res_t burst[$];
			if (rq.req_type == REQ_START) begin
				bus_phase = PH_COMMAND;
				saved_status = '0;
				saved_message = '0;
				burst.push_back(issue(CMD_FLUSH, rq.target_id, '0));
				burst.push_back(issue(CMD_SELECT, rq.target_id, '0));
			end else if (rq.interrupt_flags[INT_BUS_RESET]) begin
				bus_phase = PH_IDLE;
				burst.push_back(conclude(CC_RESET, '0, '0));
			end else if (rq.pio_reg[PIO_ERROR]) begin
				bus_phase = PH_IDLE;
				burst.push_back(conclude(CC_ERROR, '0, '0));
			end else if (rq.chip_status[ST_PARITY]) begin
				bus_phase = PH_IDLE;
				burst.push_back(conclude(CC_PARITY, '0, '0));
			end else if (rq.chip_status[ST_GROSS]) begin
				bus_phase = PH_IDLE;
				burst.push_back(conclude(CC_ERROR, '0, '0));
			end else if (rq.interrupt_flags[INT_DISCONNECT]) begin
				if (bus_phase == PH_MSG_IN)
					burst.push_back(conclude(CC_OK, saved_status, saved_message));
				else
					burst.push_back(conclude(CC_NO_CONNECT, '0, '0));
				bus_phase = PH_IDLE;
			end else begin
				case (rq.chip_status[2:0])
					BP_DATA_OUT, BP_DATA_IN: begin
						if (rq.interrupt_flags[INT_SERVICE]) begin
							bus_phase = (rq.chip_status[2:0] == BP_DATA_IN) ? PH_DATA_IN : PH_DATA_OUT;
							burst.push_back(issue(CMD_FLUSH, '0, '0));
							burst.push_back(issue(CMD_XFER_DMA, '0, rq.transfer_length));
						end
					end
					BP_COMMAND: bus_phase = PH_COMMAND;
					BP_STATUS: begin
						bus_phase = PH_STATUS;
						burst.push_back(issue(CMD_FLUSH, '0, '0));
						burst.push_back(issue(CMD_COMPLETE, '0, '0));
					end
					BP_MSG_OUT: begin
						bus_phase = PH_MSG_OUT;
						burst.push_back(issue(CMD_SET_ATN, '0, '0));
						burst.push_back(issue(CMD_MSG_ACCEPT, '0, '0));
					end
					BP_MSG_IN: begin
						bus_phase = PH_MSG_IN;
						saved_status = rq.fifo_first_byte;
						saved_message = rq.fifo_second_byte;
						if (rq.fifo_second_byte == MSG_SAVE_PTR ||
								rq.fifo_second_byte == MSG_DISCONNECT)
							burst.push_back(issue(CMD_SET_ATN, '0, '0));
						burst.push_back(issue(CMD_MSG_ACCEPT, '0, '0));
					end
					default: ;
				endcase
				// nothing issued still shows the phase
				if (burst.size() == 0)
					burst.push_back('0);
			end
			foreach (burst[k]) begin
				burst[k].phase_now = bus_phase;
				burst[k].last = (k == burst.size() - 1);
				expected_results.push_back(burst[k]);
			end
		endfunction

		function void report(string what, res_t want, res_t got);
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] %s: expected %h, got %h", $time, what, want, got);
		endfunction

		function void check_result(res_t got);
			res_t want;
			string diff;
			if (expected_results.size() == 0) begin
				report("result transaction with nothing outstanding", '0, got);
				return;
			end
			want = expected_results.pop_front();
			diff = "";
			if (got.command_valid !== want.command_valid) diff = {diff, " command_valid"};
			if (got.chip_command !== want.chip_command) diff = {diff, " chip_command"};
			if (got.select_target !== want.select_target) diff = {diff, " select_target"};
			if (got.transfer_count !== want.transfer_count) diff = {diff, " transfer_count"};
			if (got.done_res !== want.done_res) diff = {diff, " done_res"};
			if (got.completion_code !== want.completion_code) diff = {diff, " completion_code"};
			if (got.completed_status !== want.completed_status)
				diff = {diff, " completed_status"};
			if (got.completed_message !== want.completed_message)
				diff = {diff, " completed_message"};
			if (got.phase_now !== want.phase_now) diff = {diff, " phase_now"};
			if (got.last !== want.last) diff = {diff, " last"};
			if (diff != "")
				report({"mismatch in", diff}, want, got);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int unsigned cycle_count = 0;
	int unsigned requests_sent;
	int unsigned send_calm;
	int unsigned take_calm;
	phase_sequence_checker sb;

	scsi_ips_req_if req_bus ();
	scsi_ips_res_if res_bus ();

	scsi_initiator_phase_sequencer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.res    (res_bus)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count == CYCLE_LIMIT);
		$display("FAIL scsi_initiator_phase_sequencer");
		$finish;
	end

	// occasional stretches with no idling at all
	function automatic int unsigned draw_wait(inout int unsigned calm);
		if (calm != 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 63) == 0)
			calm = $urandom_range(16, 64);
		return $urandom_range(0, 7);
	endfunction

	function automatic req_t random_request();
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		return raw[$bits(req_t)-1:0];
	endfunction

	function automatic req_t start_request(logic [2:0] tid);
		req_t rq;
		rq = random_request();
		rq.req_type = REQ_START;
		rq.target_id = tid;
		return rq;
	endfunction

	function automatic req_t phase_event(logic [2:0] bp, logic service);
		req_t rq;
		rq = random_request();
		rq.req_type = REQ_EVENT;
		rq.chip_status[2:0] = bp;
		rq.chip_status[ST_PARITY] = 1'b0;
		rq.chip_status[ST_GROSS] = 1'b0;
		rq.interrupt_flags[INT_BUS_RESET] = 1'b0;
		rq.interrupt_flags[INT_DISCONNECT] = 1'b0;
		rq.interrupt_flags[INT_SERVICE] = service;
		rq.pio_reg[PIO_ERROR] = 1'b0;
		return rq;
	endfunction

	function automatic req_t msg_in_event(logic [7:0] st, logic [7:0] msg);
		req_t rq;
		rq = phase_event(BP_MSG_IN, 1'($urandom));
		rq.fifo_first_byte = st;
		rq.fifo_second_byte = msg;
		return rq;
	endfunction

	// lower-priority condition bits stay random
	function automatic req_t fault_event(fault_e kind);
		req_t rq;
		rq = random_request();
		rq.req_type = REQ_EVENT;
		rq.interrupt_flags[INT_BUS_RESET] = (kind == FAULT_BUS_RESET);
		if (kind > FAULT_BUS_RESET) rq.pio_reg[PIO_ERROR] = (kind == FAULT_PIO);
		if (kind > FAULT_PIO) rq.chip_status[ST_PARITY] = (kind == FAULT_PARITY);
		if (kind > FAULT_PARITY) rq.chip_status[ST_GROSS] = (kind == FAULT_GROSS);
		if (kind > FAULT_GROSS) rq.interrupt_flags[INT_DISCONNECT] = 1'b1;
		return rq;
	endfunction

	function automatic logic [7:0] random_message();
		case ($urandom_range(0, 3))
			0: return MSG_SAVE_PTR;
			1: return MSG_DISCONNECT;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic push_request(req_t rq);
		int unsigned gap;
		gap = draw_wait(send_calm);
		if (gap != 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.payload <= rq;
		do @(posedge clk); while (req_bus.ready !== 1'b1);
		sb.note_request(rq);
		requests_sent++;
	endtask

	task automatic run_directed();
		req_t rq;
		push_request(msg_in_event(8'h5a, MSG_SAVE_PTR));
		push_request(fault_event(FAULT_DISCONNECT));
		push_request(start_request(3'd0));
		rq = phase_event(BP_DATA_OUT, 1'b1);
		rq.transfer_length = '0;
		push_request(rq);
		rq = phase_event(BP_DATA_IN, 1'b1);
		rq.transfer_length = '1;
		push_request(rq);
		push_request(phase_event(BP_DATA_OUT, 1'b0));
		push_request(phase_event(BP_DATA_IN, 1'b0));
		push_request(phase_event(BP_COMMAND, 1'b1));
		push_request(phase_event(BP_RESERVED_A, 1'b1));
		push_request(phase_event(BP_RESERVED_B, 1'b0));
		push_request(phase_event(BP_STATUS, 1'b1));
		push_request(phase_event(BP_MSG_OUT, 1'b1));
		push_request(msg_in_event(8'hff, MSG_DISCONNECT));
		push_request(msg_in_event(8'h00, 8'hff));
		push_request(fault_event(FAULT_DISCONNECT));
		rq = '1;
		rq.req_type = REQ_START;
		push_request(rq);
		push_request('1);
		push_request(start_request(3'd5));
		push_request(fault_event(FAULT_PIO));
		push_request(start_request(3'd2));
		push_request(fault_event(FAULT_PARITY));
		push_request(start_request(3'd6));
		push_request(fault_event(FAULT_GROSS));
		rq = '0;
		rq.req_type = REQ_EVENT;
		push_request(rq);
	endtask

	task automatic run_random();
		int unsigned steps;
		fault_e ending;
		while (requests_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 3)) push_request(random_request());
			end else begin
				push_request(start_request(3'($urandom)));
				steps = $urandom_range(0, 4);
				repeat (steps)
					push_request(phase_event(3'($urandom), $urandom_range(0, 3) != 0));
				case ($urandom_range(0, 9))
					0: ending = FAULT_BUS_RESET;
					1: ending = FAULT_PIO;
					2: ending = FAULT_PARITY;
					3: ending = FAULT_GROSS;
					default: begin
						push_request(msg_in_event(8'($urandom), random_message()));
						ending = FAULT_DISCONNECT;
					end
				endcase
				push_request(fault_event(ending));
			end
		end
	endtask

	initial begin
		int unsigned stall;
		int unsigned taken;
		wait (arst_n === 1'b1);
		taken = 0;
		forever begin
			stall = (taken == HOLD_AT) ? HOLD_CYCLES : draw_wait(take_calm);
			if (stall != 0) begin
				res_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
			do @(posedge clk); while (res_bus.valid !== 1'b1);
			sb.check_result(res_bus.payload);
			taken++;
		end
	end

	initial begin
		sb = new();
		requests_sent = 0;
		send_calm = 0;
		take_calm = 0;
		arst_n <= 1'b0;
		req_bus.valid <= 1'b0;
		req_bus.payload <= '0;
		res_bus.ready <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		req_bus.valid <= 1'b0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_results.size() == 0)
			$display("PASS scsi_initiator_phase_sequencer");
		else
			$display("FAIL scsi_initiator_phase_sequencer");
		$finish;
	end

endmodule

FILE: files.f
sv/scsi_ips_pkg.sv
sv/scsi_ips_req_if.sv
sv/scsi_ips_res_if.sv
sv/scsi_ips_decode.sv
sv/scsi_initiator_phase_sequencer.sv
dv/tb_scsi_initiator_phase_sequencer.sv
